@@ hw/rtl/tiled_rgb565_to_rgb888_detiler_core_macros.svh @@
// Assertion macros for the RGB565 detiler checker.
// Needs nothing else; included by the checker file.
`ifndef TILED_RGB565_TO_RGB888_DETILER_CORE_MACROS_SVH
`define TILED_RGB565_TO_RGB888_DETILER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DETIL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DETIL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/detil_pkg.sv @@
// Shared types, constants and colour expansion for the RGB565 detiler.
// No dependencies.
package detil_pkg;

  localparam int MAX_TILES_DEF = 8;
  localparam int SIZE_W        = 4;
  localparam int PIXEL_W       = 16;
  localparam int OFFSET_W      = 14;
  localparam int CHAN_W        = 8;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 40;
  localparam int CFG_ADDR_W    = 1;

  localparam logic [SIZE_W-1:0]     SIZE_RESET       = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_TILES  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_TILES = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic                last;
  } addr_info_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb888_t;

  typedef struct packed {
    addr_info_t addr;
    rgb888_t    rgb;
  } out_item_t;

  // Shift each channel up to eight bits, zero fill below.
  function automatic rgb888_t expand_565(input logic [PIXEL_W-1:0] pix);
    rgb888_t c;
    c.blue  = {pix[4:0], 3'b000};
    c.green = {pix[10:5], 2'b00};
    c.red   = {pix[15:11], 3'b000};
    return c;
  endfunction

endpackage

@@ hw/rtl/tiled_rgb565_to_rgb888_detiler_core.sv @@
// An accepted input word is shown as a result word in the next cycle.
// Throughput: one word per cycle while out_tready is high; the result register refills as it drains.
// Reset (rst_n low, synchronous): counters to zero, width and height to
// 3 tiles, result register empty.
// Depends on detil_pkg, detil_addr_gen, detil_out_stage.
module tiled_rgb565_to_rgb888_detiler_core #(
  parameter int MAX_TILES = detil_pkg::MAX_TILES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [detil_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [detil_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [detil_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] pixel_565
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [13:0] byte_offset, [21:14] blue, [29:22] green, [37:30] red, [39:38] zero
  output logic [detil_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                               out_tlast   // last_of_image
);
  import detil_pkg::*;

  logic       accept;
  addr_info_t info;
  out_item_t  item_in, item_out;

  assign accept = in_tvalid && in_tready;

  detil_addr_gen #(
    .MAX_TILES(MAX_TILES)
  ) u_addr_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .advance  (accept),
    .info     (info)
  );

  always_comb begin
    item_in.addr = info;
    item_in.rgb  = expand_565(in_tdata[PIXEL_W-1:0]);
  end

  detil_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_tvalid),
    .item_in (item_in),
    .take    (out_tready),
    .can_load(in_tready),
    .valid   (out_tvalid),
    .item_out(item_out)
  );

  assign out_tdata = {2'b00, item_out.rgb.red, item_out.rgb.green, item_out.rgb.blue,
                      item_out.addr.byte_offset};
  assign out_tlast = item_out.addr.last;

endmodule

@@ hw/rtl/detil_addr_gen.sv @@
// Size registers, tile/Morton position counters and byte offset generation.
// Depends on detil_pkg.
module detil_addr_gen #(
  parameter int MAX_TILES = detil_pkg::MAX_TILES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [detil_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [detil_pkg::SIZE_W-1:0]        cfg_wdata,
  input  logic                                advance,
  output detil_pkg::addr_info_t               info
);
  import detil_pkg::*;

  localparam int CW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int EW = $clog2(MAX_TILES + 1);

  logic [SIZE_W-1:0] width_tiles_r, height_tiles_r;
  logic [CW-1:0]     tile_col_r, tile_col_nxt;
  logic [CW-1:0]     tile_row_r, tile_row_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [EW-1:0]     w_eff, h_eff;
  logic              col_last, row_last, tile_end;
  logic [2:0]        lx, ly;
  logic [CW+2:0]     x, y;
  logic [OFFSET_W-1:0] yw, lin;

  function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [EW-1:0] e;
    if (r == '0) begin
      e = EW'(1);
    end else if (32'(r) > MAX_TILES) begin
      e = EW'(MAX_TILES);
    end else begin
      e = EW'(r);
    end
    return e;
  endfunction

  always_comb begin
    w_eff    = eff_size(width_tiles_r);
    h_eff    = eff_size(height_tiles_r);
    col_last = (32'(tile_col_r) + 32'd1) >= 32'(w_eff);
    row_last = (32'(tile_row_r) + 32'd1) >= 32'(h_eff);
    tile_end = (pos_r == 6'h3F);
    // Morton order: even bits give x, odd bits give y
    lx  = {pos_r[4], pos_r[2], pos_r[0]};
    ly  = {pos_r[5], pos_r[3], pos_r[1]};
    x   = {tile_col_r, lx};
    y   = {tile_row_r, ly};
    yw  = OFFSET_W'(y) * OFFSET_W'(w_eff);
    lin = (yw << 3) + OFFSET_W'(x);
    info.byte_offset = (lin << 1) + lin;
    info.last        = tile_end && col_last && row_last;

    pos_nxt      = pos_r + 6'd1;
    tile_col_nxt = tile_col_r;
    tile_row_nxt = tile_row_r;
    if (tile_end) begin
      if (col_last) begin
        tile_col_nxt = '0;
        tile_row_nxt = row_last ? '0 : tile_row_r + 1'b1;
      end else begin
        tile_col_nxt = tile_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_tiles_r  <= SIZE_RESET;
      height_tiles_r <= SIZE_RESET;
      tile_col_r     <= '0;
      tile_row_r     <= '0;
      pos_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WIDTH_TILES:  width_tiles_r  <= cfg_wdata;
          REG_HEIGHT_TILES: height_tiles_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (advance) begin
        pos_r      <= pos_nxt;
        tile_col_r <= tile_col_nxt;
        tile_row_r <= tile_row_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/detil_out_stage.sv @@
// Result register with valid/ready handshake.
// Depends on detil_pkg.
module detil_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  detil_pkg::out_item_t  item_in,
  input  logic                  take,
  output logic                  can_load,
  output logic                  valid,
  output detil_pkg::out_item_t  item_out
);
  import detil_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  // Refill in the cycle the held word leaves
  assign can_load = !valid_r || take;
  assign valid    = valid_r;
  assign item_out = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      item_r <= item_in;
    end
  end

endmodule

@@ hw/rtl/detil_checker.sv @@
// Port-level checks for the RGB565 detiler, bound to the top level.
// Depends on detil_pkg and the macros header.
`include "tiled_rgb565_to_rgb888_detiler_core_macros.svh"

module detil_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [detil_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [detil_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                               out_tlast
);
  import detil_pkg::*;

  // A stalled result word must hold
  `DETIL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result word changed")

  // An accepted input word shows up as a result in the next cycle
  `DETIL_ASSERT_NEXT(a_one_cycle, clk, rst_n, in_tvalid && in_tready, out_tvalid && $past(in_tdata[4:0]) == out_tdata[21:17], "result word missing or wrong after accept")

  // Full result register with a stalled sink blocks the input
  `DETIL_ASSERT_SAME(a_backpressure, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken while result register is full")

  // Zero fill below each expanded channel and in the padding
  `DETIL_ASSERT_SAME(a_zero_fill, clk, rst_n, out_tvalid, out_tdata[16:14] == 3'b000 && out_tdata[23:22] == 2'b00 && out_tdata[32:30] == 3'b000 && out_tdata[39:38] == 2'b00, "colour zero fill broken")

endmodule

bind tiled_rgb565_to_rgb888_detiler_core detil_checker u_detil_checker (.*);

@@ test/testbench.sv @@
// Self-checking bench for tiled_rgb565_to_rgb888_detiler_core: a table of directed
// pixels, then random pixel runs between size changes; scored against a tile walker or table words.
// Depends on detil_pkg and the detiler RTL.
module testbench;
  import detil_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RAND_ITEMS   = 1580;
  localparam int QUIET_TAIL   = 200;
  localparam int LONG_HOLD    = 60;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   red;
    logic                last;
  } pixel_word_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_FILL, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [SIZE_W-1:0]     reg_val;
    int                    count;
    logic [PIXEL_W-1:0]    pix;
    bit                    typed;
    pixel_word_t           word;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [SIZE_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // Walker state and size registers as the block should hold them
  logic [2:0]        trk_col;
  logic [2:0]        trk_row;
  logic [5:0]        trk_pos;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  pixel_word_t pending_pixels[$];
  stim_row_t   rows[$];
  pixel_word_t got;
  pixel_word_t want;

  int  n_fail;
  int  n_seen;
  int  n_cycles;
  int  n_rand;
  int  calm_in;
  bit  quiet;
  bit  long_hold_done;

  tiled_rgb565_to_rgb888_detiler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int eff_tiles(input logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_TILES_DEF) return MAX_TILES_DEF;
    return int'(r);
  endfunction

  // Place one pixel in the linear frame and step the tile walker
  function automatic pixel_word_t detile_step(input logic [PIXEL_W-1:0] pix);
    pixel_word_t w;
    int wt, ht, lx, ly, x, y, ofs;
    bit col_last, row_last, tile_end;
    wt = eff_tiles(width_reg);
    ht = eff_tiles(height_reg);
    lx = int'({trk_pos[4], trk_pos[2], trk_pos[0]});
    ly = int'({trk_pos[5], trk_pos[3], trk_pos[1]});
    x = int'(trk_col) * 8 + lx;
    y = int'(trk_row) * 8 + ly;
    ofs = (y * wt * 8 + x) * 3;
    col_last = (int'(trk_col) + 1) >= wt;
    row_last = (int'(trk_row) + 1) >= ht;
    tile_end = (trk_pos == 6'd63);
    w.offset = ofs[OFFSET_W-1:0];
    w.blue   = {pix[4:0], 3'b000};
    w.green  = {pix[10:5], 2'b00};
    w.red    = {pix[15:11], 3'b000};
    w.last   = tile_end && col_last && row_last;
    if (!tile_end) begin
      trk_pos = trk_pos + 6'd1;
    end else begin
      trk_pos = '0;
      if (!col_last) begin
        trk_col = trk_col + 3'd1;
      end else begin
        trk_col = '0;
        trk_row = row_last ? 3'd0 : trk_row + 3'd1;
      end
    end
    return w;
  endfunction

  function automatic void flag(input string what, input pixel_word_t w, input pixel_word_t g,
                               input logic [1:0] pad);
    n_fail++;
    if (n_fail <= 10) begin
      $write("%s: want off=%0d b=%02h g=%02h r=%02h last=%0b | ",
             what, w.offset, w.blue, w.green, w.red, w.last);
      $display("got off=%0d b=%02h g=%02h r=%02h last=%0b pad=%0d",
               g.offset, g.blue, g.green, g.red, g.last, pad);
    end
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 4'd15;
      2:       return 4'd8;
      3:       return SIZE_W'($urandom_range(9, 15));
      4:       return SIZE_W'($urandom_range(0, 15));
      default: return SIZE_W'($urandom_range(1, 2));
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pixel_word_t mk_word(input int ofs, input int b, input int g, input int r,
                                          input bit l);
    pixel_word_t w;
    w.offset = OFFSET_W'(ofs);
    w.blue   = CHAN_W'(b);
    w.green  = CHAN_W'(g);
    w.red    = CHAN_W'(r);
    w.last   = l;
    return w;
  endfunction

  function automatic void row_size(input logic [CFG_ADDR_W-1:0] idx, input int val);
    stim_row_t s;
    s = '{kind: ROW_SIZE, reg_idx: idx, reg_val: SIZE_W'(val), count: 0, pix: '0,
          typed: 1'b0, word: '0};
    rows.push_back(s);
  endfunction

  function automatic void row_pix(input int pix, input bit typed, input pixel_word_t w);
    stim_row_t s;
    s = '{kind: ROW_PIXEL, reg_idx: '0, reg_val: '0, count: 0, pix: PIXEL_W'(pix),
          typed: typed, word: w};
    rows.push_back(s);
  endfunction

  function automatic void row_fill(input int n);
    stim_row_t s;
    s = '{kind: ROW_FILL, reg_idx: '0, reg_val: '0, count: n, pix: '0,
          typed: 1'b0, word: '0};
    rows.push_back(s);
  endfunction

  // Offer one pixel, with an occasional gap first; record its result on acceptance
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit typed,
                            input pixel_word_t typed_word);
    pixel_word_t w;
    if (calm_in > 0) begin
      calm_in--;
    end else if (!quiet) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        2: calm_in = $urandom_range(20, 60);
        default: ;
      endcase
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    w = detile_step(pix);
    pending_pixels.push_back(typed ? typed_word : w);
  endtask

  // Drop valid and hold until every result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_ADDR_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_WIDTH_TILES) width_reg = val;
    else height_reg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: score each word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_seen++;
      got.offset = out_tdata[13:0];
      got.blue   = out_tdata[21:14];
      got.green  = out_tdata[29:22];
      got.red    = out_tdata[37:30];
      got.last   = out_tlast;
      if (pending_pixels.size() == 0) begin
        flag("unexpected word", '0, got, out_tdata[39:38]);
      end else begin
        want = pending_pixels.pop_front();
        if (got != want || out_tdata[39:38] != 2'b00)
          flag("mismatch", want, got, out_tdata[39:38]);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("tiled_rgb565_to_rgb888_detiler_core test failed");
      $finish;
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off to back up the input
  initial begin
    int calm_out;
    calm_out = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && n_seen >= 400) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (calm_out > 0 || quiet) begin
        if (calm_out > 0) calm_out--;
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            out_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
          end
          2: begin
            calm_out = $urandom_range(20, 60);
            out_tready <= 1'b1;
            @(posedge clk);
          end
          default: begin
            out_tready <= 1'b1;
            @(posedge clk);
          end
        endcase
      end
    end
  end

  initial begin
    int len;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    n_fail = 0;
    n_seen = 0;
    n_cycles = 0;
    n_rand = 0;
    calm_in = 0;
    quiet = 1'b0;
    long_hold_done = 1'b0;
    trk_col = '0;
    trk_row = '0;
    trk_pos = '0;
    width_reg  = SIZE_RESET;
    height_reg = SIZE_RESET;

    // Reset sizes are 3x3 tiles: first pixels of the first tile in Morton order
    row_pix(16'hFFFF, 1, mk_word(0, 8'hF8, 8'hFC, 8'hF8, 0));
    row_pix(16'h0000, 1, mk_word(3, 0, 0, 0, 0));
    row_pix(16'h001F, 1, mk_word(72, 8'hF8, 0, 0, 0));
    row_pix(16'h07E0, 1, mk_word(75, 0, 8'hFC, 0, 0));
    row_pix(16'hF800, 1, mk_word(6, 0, 0, 8'hF8, 0));
    // Zero sizes mid-image act as one tile; finish that tile to reach the image end
    row_size(REG_WIDTH_TILES, 0);
    row_size(REG_HEIGHT_TILES, 0);
    row_pix(16'h1234, 0, '0);
    row_fill(57);
    row_pix(16'hA5A5, 1, mk_word(189, 8'h28, 8'hB4, 8'hA0, 1));
    // Oversized registers clamp to the largest image
    row_size(REG_WIDTH_TILES, 15);
    row_size(REG_HEIGHT_TILES, 9);
    row_pix(16'h0001, 1, mk_word(0, 8'h08, 0, 0, 0));
    row_pix(16'h0020, 1, mk_word(3, 0, 8'h04, 0, 0));
    row_pix(16'h0800, 1, mk_word(192, 0, 0, 8'h08, 0));
    row_size(REG_WIDTH_TILES, 8);
    row_size(REG_HEIGHT_TILES, 1);
    row_pix(16'hFFFE, 0, '0);
    row_pix(16'h8000, 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_SIZE: begin
          drain();
          write_size(rows[i].reg_idx, rows[i].reg_val);
        end
        ROW_FILL: begin
          repeat (rows[i].count) send_pixel(rand_pixel(), 1'b0, '0);
        end
        default: send_pixel(rows[i].pix, rows[i].typed, rows[i].word);
      endcase
    end

    // Random runs, each after a pause for idle and a possible size change
    while (n_rand < RAND_ITEMS) begin
      drain();
      if ($urandom_range(0, 3) != 0) write_size(REG_WIDTH_TILES, pick_size());
      if ($urandom_range(0, 3) != 0) write_size(REG_HEIGHT_TILES, pick_size());
      len = $urandom_range(1, 160);
      if (len > RAND_ITEMS - n_rand) len = RAND_ITEMS - n_rand;
      repeat (len) begin
        send_pixel(rand_pixel(), 1'b0, '0);
        n_rand++;
        quiet = (n_rand >= RAND_ITEMS - QUIET_TAIL);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (n_fail == 0 && pending_pixels.size() == 0) begin
      $display("tiled_rgb565_to_rgb888_detiler_core test passed");
    end else begin
      $display("tiled_rgb565_to_rgb888_detiler_core test failed");
    end
    $finish;
  end

endmodule
